@@ hdl/tint_pkg.sv @@
// Shared constants, types and sequencer phases of the trapezoid integrator.
package tint_pkg;

  // Fixed-point formats
  localparam int FRACTION_BITS     = 16;
  localparam int LOG_FRACTION_BITS = 24;

  // Datapath widths
  localparam int X_W   = 32;
  localparam int Y_W   = 32;
  localparam int W_W   = 64;
  localparam int SUM_W = 64;
  localparam int LX_W  = 32;
  localparam int MUL_W = 32;
  localparam int ACC_W = 96;
  localparam int MSB_W = 5;
  localparam int INT_W = 7;
  localparam int LG_W  = LOG_FRACTION_BITS + INT_W;

  // Binary search for the leading one: shifts of 16, 8, 4, 2, 1
  localparam int NORM_STEPS = 5;
  localparam logic [MSB_W-1:0] NORM_FIRST_SHIFT = 5'd16;
  localparam logic [MSB_W-1:0] MSB_START        = 5'd31;

  // Step counter covers both the search and the squaring loop
  localparam int CNT_W = $clog2(LOG_FRACTION_BITS);

  // ln 2 in Q0.32
  localparam logic [MUL_W-1:0] LN2_Q32 = 32'hB172_17F8;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FEW_POINTS = 2'd1,
    STATUS_ZERO_X    = 2'd2,
    STATUS_SATURATED = 2'd3
  } status_t;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_NORM,
    PH_SQUARE,
    PH_LN,
    PH_DIFF,
    PH_SEG_LO,
    PH_SEG_HI,
    PH_SUM,
    PH_SCALE,
    PH_ACCUM
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [CNT_W-1:0] step;
  } ctrl_t;

endpackage

@@ hdl/tint_mul.sv @@
// Shared 32 x 32 unsigned multiplier of the trapezoid integrator.
module tint_mul (
  input  logic [tint_pkg::MUL_W-1:0]   a,
  input  logic [tint_pkg::MUL_W-1:0]   b,
  output logic [2*tint_pkg::MUL_W-1:0] p
);
  import tint_pkg::*;

  // Form the full-width product; callers register it
  assign p = {{MUL_W{1'b0}}, a} * {{MUL_W{1'b0}}, b};

endmodule

@@ hdl/tint_ctrl.sv @@
// Sequencer of the trapezoid integrator: phase and step counter.
module tint_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            finish_ok,
  output tint_pkg::ctrl_t ctrl
);
  import tint_pkg::*;

  phase_t           state;
  phase_t           state_next;
  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] step_next;

  // Hold phase and step
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Advance through the phases
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      PH_IDLE: begin
        if (start) begin
          state_next = PH_NORM;
          step_next  = '0;
        end
      end
      PH_NORM: begin
        if (step == CNT_W'(NORM_STEPS - 1)) begin
          state_next = PH_SQUARE;
          step_next  = '0;
        end else begin
          step_next = step + CNT_W'(1);
        end
      end
      PH_SQUARE: begin
        if (step == CNT_W'(LOG_FRACTION_BITS - 1)) begin
          state_next = PH_LN;
          step_next  = '0;
        end else begin
          step_next = step + CNT_W'(1);
        end
      end
      PH_LN:     state_next = PH_DIFF;
      PH_DIFF:   state_next = PH_SEG_LO;
      PH_SEG_LO: state_next = PH_SEG_HI;
      PH_SEG_HI: state_next = PH_SUM;
      PH_SUM:    state_next = PH_SCALE;
      PH_SCALE:  state_next = PH_ACCUM;
      PH_ACCUM: begin
        if (finish_ok) begin
          state_next = PH_IDLE;
        end
      end
      default: begin
        state_next = PH_IDLE;
        step_next  = '0;
      end
    endcase
  end

  // Drive the control bundle
  always_comb begin
    ctrl.phase = state;
    ctrl.step  = step;
  end

endmodule

@@ hdl/trapezoid_integrator_core.sv @@
// Each item steps through norm, square, ln, diff, seg_lo, seg_hi, sum, scale and accum;
// a new item is taken only in idle, once accum is done. The LOG_FRACTION_BITS squaring steps of the
// logarithm dominate, all on one shared 32 x 32 multiplier with a 5-step leading-one search.
// A finished result waits in the output register while the next item is taken in.
// Reset (rst, synchronous) clears log_mode, the run state, the output valid flag and the sequencer.
module trapezoid_integrator_core (
  input  logic        clk,
  input  logic        rst,
  // Configuration: log_mode
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] x_value, [63:32] y_value
  input  logic        s_axis_tlast,   // last_point
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // [63:0] integral, [65:64] status, [71:66] zero
);
  import tint_pkg::*;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [LX_W-1:0]  LX_MAX  = {1'b0, {(LX_W-1){1'b1}}};
  localparam logic [LX_W-1:0]  LX_MIN  = {1'b1, {(LX_W-1){1'b0}}};

  ctrl_t ctrl;

  // Configuration and captured item
  logic              log_mode;
  logic              mode_q;
  logic [X_W-1:0]    x_q;
  logic [Y_W-1:0]    y_q;
  logic              last_q;

  // Logarithm working registers
  logic [MUL_W-1:0]             mant;
  logic [MSB_W-1:0]             msb;
  logic [LOG_FRACTION_BITS-1:0] frac;

  // Per-point values and segment product
  logic [W_W-1:0]    w_q;
  logic [LX_W-1:0]   lx_q;
  logic [SUM_W-1:0]  smag;
  logic [MUL_W-1:0]  dmag;
  logic              pneg;
  logic [ACC_W-1:0]  acc;
  logic [2*MUL_W-1:0] pp;
  logic [SUM_W-1:0]  seg;
  logic              seg_ovf;

  // Run state
  logic [X_W-1:0]    prev_x;
  logic [LX_W-1:0]   prev_lx;
  logic [W_W-1:0]    prev_w;
  logic [SUM_W-1:0]  run_sum;
  logic [1:0]        points_seen;
  status_t           run_status;

  // Output register
  logic              out_valid;
  logic [SUM_W-1:0]  out_integral;
  status_t           out_status;

  // Shared multiplier operands
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [2*MUL_W-1:0] mul_p;

  // Combinational helpers
  logic               in_fire;
  logic               accum_go;
  logic [MUL_W-1:0]   y_mag;
  logic [W_W-1:0]     w_next;
  logic [MSB_W-1:0]   shamt;
  logic               top_clear;
  logic [INT_W-1:0]   int_part;
  logic [LG_W-1:0]    lg;
  logic [LG_W-1:0]    lg_mag;
  logic               lg_neg;
  logic [MUL_W-1:0]   ln_q;
  logic [MUL_W-1:0]   ln_q_neg;
  logic [LX_W-1:0]    lx_next;
  logic [SUM_W:0]     sum65;
  logic [SUM_W:0]     sum65_neg;
  logic [X_W:0]       diff33;
  logic [X_W:0]       diff33_neg;
  logic [ACC_W-1:0]   shifted;
  logic [SUM_W-1:0]   limit;
  logic               scale_ovf;
  logic [SUM_W-1:0]   qv;
  status_t            rs_pre;
  logic               do_seg;
  logic [SUM_W:0]     add65;
  logic               add_ovf;
  logic [SUM_W-1:0]   add_val;
  logic [SUM_W-1:0]   sum_new;
  status_t            rs_new;
  logic [1:0]         ps_new;
  status_t            fin_status;
  logic [SUM_W-1:0]   fin_integral;

  tint_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (in_fire),
    .finish_ok (accum_go),
    .ctrl      (ctrl)
  );

  tint_mul u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (mul_p)
  );

  // Handshakes
  assign s_axis_tready = (ctrl.phase == PH_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign accum_go      = (ctrl.phase == PH_ACCUM) &&
                         (!last_q || !out_valid || m_axis_tready);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_status, out_integral};

  // Select multiplier operands by phase
  always_comb begin
    case (ctrl.phase)
      PH_NORM: begin
        mul_a = y_mag;
        mul_b = x_q;
      end
      PH_SQUARE: begin
        mul_a = mant;
        mul_b = mant;
      end
      PH_LN: begin
        mul_a = MUL_W'(lg_mag);
        mul_b = LN2_Q32;
      end
      PH_SEG_LO: begin
        mul_a = smag[MUL_W-1:0];
        mul_b = dmag;
      end
      PH_SEG_HI: begin
        mul_a = smag[SUM_W-1:MUL_W];
        mul_b = dmag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Weighted ordinate: y, or y*x in log mode
  always_comb begin
    y_mag  = y_q[Y_W-1] ? (~y_q + 1'b1) : y_q;
    if (mode_q) begin
      w_next = y_q[Y_W-1] ? (~mul_p + 1'b1) : mul_p;
    end else begin
      w_next = {{(W_W-Y_W){y_q[Y_W-1]}}, y_q};
    end
  end

  // Leading-one search step
  always_comb begin
    shamt     = NORM_FIRST_SHIFT >> ctrl.step;
    top_clear = (mant & ~({MUL_W{1'b1}} >> shamt)) == '0;
  end

  // Scale log2 by ln 2 and clamp
  always_comb begin
    int_part = INT_W'(msb) - INT_W'(FRACTION_BITS);
    lg       = {int_part, frac};
    lg_neg   = int_part[INT_W-1];
    lg_mag   = lg_neg ? (~lg + 1'b1) : lg;
    ln_q     = mul_p[2*MUL_W-1:MUL_W];
    ln_q_neg = ~ln_q + 1'b1;
    if (x_q == '0) begin
      lx_next = '0;
    end else if (lg_neg) begin
      lx_next = (ln_q > LX_MIN) ? LX_MIN : ln_q_neg;
    end else begin
      lx_next = (ln_q > LX_MAX) ? LX_MAX : ln_q;
    end
  end

  // Ordinate sum and abscissa step as sign and magnitude
  always_comb begin
    sum65      = {prev_w[W_W-1], prev_w} + {w_q[W_W-1], w_q};
    sum65_neg  = ~sum65 + 1'b1;
    if (mode_q) begin
      diff33 = {lx_q[LX_W-1], lx_q} - {prev_lx[LX_W-1], prev_lx};
    end else begin
      diff33 = {1'b0, x_q} - {1'b0, prev_x};
    end
    diff33_neg = ~diff33 + 1'b1;
  end

  // Halve the product, drop its fraction bits in log mode, and saturate
  always_comb begin
    shifted   = mode_q ? (acc >> (LOG_FRACTION_BITS + 1)) : (acc >> 1);
    limit     = pneg ? SUM_MIN : SUM_MAX;
    scale_ovf = (shifted[ACC_W-1:SUM_W] != '0) || (shifted[SUM_W-1:0] > limit);
    qv        = scale_ovf ? limit : shifted[SUM_W-1:0];
  end

  // Fold the segment into the run and form the result
  always_comb begin
    rs_pre  = (mode_q && (x_q == '0)) ? STATUS_ZERO_X : run_status;
    do_seg  = (points_seen != 2'd0) && (rs_pre != STATUS_ZERO_X);
    add65   = {run_sum[SUM_W-1], run_sum} + {seg[SUM_W-1], seg};
    add_ovf = add65[SUM_W] != add65[SUM_W-1];
    if (add_ovf) begin
      add_val = add65[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      add_val = add65[SUM_W-1:0];
    end
    sum_new = do_seg ? add_val : run_sum;
    rs_new  = (do_seg && (seg_ovf || add_ovf)) ? STATUS_SATURATED : rs_pre;
    ps_new  = (points_seen == 2'd2) ? 2'd2 : points_seen + 2'd1;
    fin_status = (ps_new < 2'd2) ? STATUS_FEW_POINTS : rs_new;
    if ((fin_status == STATUS_FEW_POINTS) || (fin_status == STATUS_ZERO_X)) begin
      fin_integral = '0;
    end else begin
      fin_integral = sum_new;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      log_mode <= 1'b0;
    end else if (cfg_we) begin
      log_mode <= cfg_wdata;
    end
  end

  // Datapath registers, stepped by phase
  always_ff @(posedge clk) begin
    case (ctrl.phase)
      PH_IDLE: begin
        if (in_fire) begin
          x_q    <= s_axis_tdata[X_W-1:0];
          y_q    <= s_axis_tdata[X_W+Y_W-1:X_W];
          last_q <= s_axis_tlast;
          mode_q <= log_mode;
          mant   <= s_axis_tdata[X_W-1:0];
          msb    <= MSB_START;
        end
      end
      PH_NORM: begin
        w_q <= w_next;
        if (top_clear) begin
          mant <= mant << shamt;
          msb  <= msb - shamt;
        end
      end
      PH_SQUARE: begin
        if (mul_p[2*MUL_W-1]) begin
          mant <= mul_p[2*MUL_W-1:MUL_W];
        end else begin
          mant <= mul_p[2*MUL_W-2:MUL_W-1];
        end
        frac <= {frac[LOG_FRACTION_BITS-2:0], mul_p[2*MUL_W-1]};
      end
      PH_LN: begin
        lx_q <= lx_next;
      end
      PH_DIFF: begin
        smag <= sum65[SUM_W] ? sum65_neg[SUM_W-1:0] : sum65[SUM_W-1:0];
        dmag <= diff33[X_W] ? diff33_neg[MUL_W-1:0] : diff33[MUL_W-1:0];
        pneg <= sum65[SUM_W] ^ diff33[X_W];
      end
      PH_SEG_LO: begin
        acc <= {{(ACC_W-2*MUL_W){1'b0}}, mul_p};
      end
      PH_SEG_HI: begin
        pp <= mul_p;
      end
      PH_SUM: begin
        acc <= acc + {pp, {MUL_W{1'b0}}};
      end
      PH_SCALE: begin
        seg     <= pneg ? (~qv + 1'b1) : qv;
        seg_ovf <= scale_ovf;
      end
      default: begin
      end
    endcase
  end

  // Run state: advance on each point, clear after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x      <= '0;
      prev_lx     <= '0;
      prev_w      <= '0;
      run_sum     <= '0;
      points_seen <= 2'd0;
      run_status  <= STATUS_OK;
    end else if (accum_go) begin
      if (last_q) begin
        prev_x      <= '0;
        prev_lx     <= '0;
        prev_w      <= '0;
        run_sum     <= '0;
        points_seen <= 2'd0;
        run_status  <= STATUS_OK;
      end else begin
        prev_x      <= x_q;
        prev_lx     <= lx_q;
        prev_w      <= w_q;
        run_sum     <= sum_new;
        points_seen <= ps_new;
        run_status  <= rs_new;
      end
    end
  end

  // Output register: load on the last point, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accum_go && last_q) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accum_go && last_q) begin
      out_integral <= fin_integral;
      out_status   <= fin_status;
    end
  end

endmodule
